[rtl/core/avpl_pkg.sv]
package avpl_pkg;

  localparam int LineBufferDef = 128;
  localparam logic [6:0] LimitReset = 7'd127;
  localparam logic [6:0] ConfMax = 7'd100;

  typedef enum logic [3:0] {
    KIND_TAG     = 4'd0,
    KIND_BAD_TAG = 4'd1,
    KIND_QR      = 4'd2,
    KIND_CLS     = 4'd3,
    KIND_BAD_CLS = 4'd4,
    KIND_ERR     = 4'd5,
    KIND_OK      = 4'd6,
    KIND_HB      = 4'd7,
    KIND_DOLLAR  = 4'd8,
    KIND_OTHER   = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  localparam logic [1:0] AddrLineLimit = 2'd0;

  typedef struct packed {
    logic        func;
    logic [7:0]  rx_byte;
    logic        byte_bad;
    logic [31:0] now_tick;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] tag_id;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] tag_dist;
    logic signed [15:0] tag_angle;
    logic signed [15:0] tag_wid;
    logic signed [15:0] cls_id;
    logic [6:0]         confidence;
    logic               ai_ready;
    logic               fault_flag;
    logic [31:0]        line_tick;
  } out_item_t;

endpackage

[rtl/core/avpl_line_core.sv]
module avpl_line_core #(
  parameter int LINE_BUFFER = avpl_pkg::LineBufferDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  avpl_pkg::in_item_t  item,
  input  logic [6:0]          line_limit,
  output logic                res_valid,
  output avpl_pkg::out_item_t res
);

  localparam logic [6:0] LimMax = 7'(LINE_BUFFER - 1);

  logic [6:0]  cc_r, cc_nxt;
  logic        ovl_r, ovl_nxt;
  logic [7:0]  pre_r [6];
  logic [7:0]  pre_nxt [6];
  logic [2:0]  fi_r, fi_nxt;
  avpl_pkg::phase_t ph_r, ph_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [15:0] fld_r [6];
  logic [15:0] fld_nxt [6];
  logic        fail_r, fail_nxt;
  logic        rdy_r, rdy_nxt;
  logic        err_r, err_nxt;

  logic [7:0]  c;
  logic [3:0]  dval;
  logic        digit;
  logic [6:0]  lim;
  logic        tag5, cls5;
  logic [31:0] p4;
  logic [15:0] sv;
  logic [30:0] mag;
  logic [34:0] next_mag;
  logic [15:0] fld_st [6];
  logic [2:0]  fi_st;
  logic [2:0]  fi_e;
  logic [15:0] fld_e [6];
  logic        cut;
  logic        st;
  logic [2:0]  target;

  always_comb begin
    c     = item.rx_byte;
    digit = (c >= "0") && (c <= "9");
    dval  = 4'(c - "0");
    lim   = (line_limit > LimMax) ? LimMax : line_limit;
    tag5  = {pre_r[0], pre_r[1], pre_r[2], pre_r[3], pre_r[4]} == "$TAG,";
    cls5  = {pre_r[0], pre_r[1], pre_r[2], pre_r[3], pre_r[4]} == "$CLS,";
    p4    = {pre_r[0], pre_r[1], pre_r[2], pre_r[3]};
    target = cls5 ? 3'd2 : 3'd6;
    mag   = acc_r[30:0];
    next_mag = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {31'd0, dval};

    // value a finished number stores, confidence clamped
    if (cls5 && fi_r == 3'd1) begin
      if (neg_r && (mag != '0 || acc_r[31])) sv = '0;
      else if (acc_r[31] || mag > 31'(avpl_pkg::ConfMax)) sv = 16'(avpl_pkg::ConfMax);
      else sv = mag[15:0];
    end else begin
      sv = neg_r ? (~mag[15:0] + 16'd1) : mag[15:0];
    end
    for (int i = 0; i < 6; i++) begin
      fld_st[i] = (fi_r == 3'(i)) ? sv : fld_r[i];
    end
    fi_st = fi_r + 3'd1;

    cut = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < cc_r[2:0] && pre_r[i] == 8'd0) cut = 1'b1;
    end

    cc_nxt = cc_r; ovl_nxt = ovl_r; fi_nxt = fi_r; ph_nxt = ph_r;
    neg_nxt = neg_r; acc_nxt = acc_r; fail_nxt = fail_r;
    rdy_nxt = rdy_r; err_nxt = err_r;
    for (int i = 0; i < 6; i++) begin
      pre_nxt[i] = pre_r[i];
      fld_nxt[i] = fld_r[i];
    end
    st = 1'b0;
    fi_e = fi_r;
    for (int i = 0; i < 6; i++) fld_e[i] = fld_r[i];
    res_valid = 1'b0;
    res = '0;
    res.kind = avpl_pkg::KIND_OTHER;

    if (go) begin
      if (item.func) begin
        rdy_nxt = 1'b0;
        err_nxt = 1'b0;
      end else if (item.byte_bad) begin
        ovl_nxt = ovl_r;
      end else if (c != 8'h0A && c != 8'h0D) begin
        if (ovl_r) begin
          ovl_nxt = 1'b1;
        end else if (cc_r >= lim) begin
          ovl_nxt = 1'b1;
        end else begin
          if (cc_r < 7'd6) pre_nxt[cc_r[2:0]] = cut ? 8'd0 : c;
          if (cc_r >= 7'd5 && (tag5 || cls5) && !fail_r && ph_r != avpl_pkg::PH_DONE) begin
            if (c == 8'd0) begin
              if (ph_r == avpl_pkg::PH_DIGIT) begin
                for (int i = 0; i < 6; i++) fld_nxt[i] = fld_st[i];
                fi_nxt = fi_st;
              end
              ph_nxt = avpl_pkg::PH_DONE;
            end else begin
              case (ph_r)
                avpl_pkg::PH_START: begin
                  if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) begin
                    ph_nxt = ph_r;
                  end else if (c == "+" || c == "-") begin
                    neg_nxt = (c == "-");
                    acc_nxt = '0;
                    ph_nxt  = avpl_pkg::PH_SIGN;
                  end else if (digit) begin
                    neg_nxt = 1'b0;
                    acc_nxt = 32'(dval);
                    ph_nxt  = avpl_pkg::PH_DIGIT;
                  end else begin
                    fail_nxt = 1'b1;
                  end
                end
                avpl_pkg::PH_SIGN: begin
                  if (digit) begin
                    acc_nxt = 32'(dval);
                    ph_nxt  = avpl_pkg::PH_DIGIT;
                  end else begin
                    fail_nxt = 1'b1;
                  end
                end
                default: begin
                  if (digit) begin
                    acc_nxt = {acc_r[31] | (next_mag > 35'h7FFFFFFF), next_mag[30:0]};
                  end else begin
                    for (int i = 0; i < 6; i++) fld_nxt[i] = fld_st[i];
                    fi_nxt = fi_st;
                    if (fi_st >= target) ph_nxt = avpl_pkg::PH_DONE;
                    else if (c == ",") ph_nxt = avpl_pkg::PH_START;
                    else fail_nxt = 1'b1;
                  end
                end
              endcase
            end
          end
          cc_nxt = cc_r + 7'd1;
        end
      end else begin
        if (!ovl_r && cc_r != 7'd0) begin
          st = !fail_r && ph_r == avpl_pkg::PH_DIGIT;
          fi_e = st ? fi_st : fi_r;
          for (int i = 0; i < 6; i++) fld_e[i] = st ? fld_st[i] : fld_r[i];
          res_valid = 1'b1;
          if (p4 == "$TAG") begin
            if (!fail_r && pre_r[4] == "," && fi_e >= 3'd6) begin
              res.kind      = avpl_pkg::KIND_TAG;
              res.tag_id    = fld_e[0];
              res.center_x  = fld_e[1];
              res.center_y  = fld_e[2];
              res.tag_dist  = fld_e[3];
              res.tag_angle = fld_e[4];
              res.tag_wid   = fld_e[5];
            end else begin
              res.kind = avpl_pkg::KIND_BAD_TAG;
            end
          end else if (p4[31:8] == "$QR") begin
            res.kind = avpl_pkg::KIND_QR;
          end else if (p4 == "$CLS") begin
            if (!fail_r && pre_r[4] == "," && fi_e >= 3'd2) begin
              res.kind       = avpl_pkg::KIND_CLS;
              res.cls_id     = fld_e[0];
              res.confidence = fld_e[1][6:0];
            end else begin
              res.kind = avpl_pkg::KIND_BAD_CLS;
            end
          end else if (p4 == "$ERR") begin
            res.kind = avpl_pkg::KIND_ERR;
            rdy_nxt  = 1'b0;
            err_nxt  = 1'b1;
          end else if (p4[31:8] == "$OK") begin
            res.kind = avpl_pkg::KIND_OK;
            if ({pre_r[3], pre_r[4], pre_r[5]} == ",BO" && !err_r) rdy_nxt = 1'b1;
          end else if (p4[31:8] == "$HB") begin
            res.kind = avpl_pkg::KIND_HB;
          end else if (pre_r[0] == "$") begin
            res.kind = avpl_pkg::KIND_DOLLAR;
          end else begin
            res.kind = avpl_pkg::KIND_OTHER;
          end
          res.ai_ready   = rdy_nxt;
          res.fault_flag = err_nxt;
          res.line_tick  = item.now_tick;
        end
        // line done, start over
        cc_nxt = '0; ovl_nxt = 1'b0; fi_nxt = '0; ph_nxt = avpl_pkg::PH_START;
        neg_nxt = 1'b0; acc_nxt = '0; fail_nxt = 1'b0;
        for (int i = 0; i < 6; i++) begin
          pre_nxt[i] = '0;
          fld_nxt[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0; ovl_r <= 1'b0; fi_r <= '0; ph_r <= avpl_pkg::PH_START;
      neg_r <= 1'b0; acc_r <= '0; fail_r <= 1'b0; rdy_r <= 1'b0; err_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        pre_r[i] <= '0;
        fld_r[i] <= '0;
      end
    end else begin
      cc_r <= cc_nxt; ovl_r <= ovl_nxt; fi_r <= fi_nxt; ph_r <= ph_nxt;
      neg_r <= neg_nxt; acc_r <= acc_nxt; fail_r <= fail_nxt;
      rdy_r <= rdy_nxt; err_r <= err_nxt;
      for (int i = 0; i < 6; i++) begin
        pre_r[i] <= pre_nxt[i];
        fld_r[i] <= fld_nxt[i];
      end
    end
  end

endmodule

[rtl/core/ascii_vision_packet_line_parser.sv]
// Line parser for an ASCII camera packet stream. One received byte per item; an item
// can be accepted every clock cycle unless the input is stalled. A completed line's
// result is registered: its terminating CR or LF is loaded into the input register,
// then the line-state update writes the result register, held back while a stalled
// result waits there. The input stalls only while a result waits, stalled, in the
// result register and the input register holds an item. Only lines that end give an
// item out; bytes, flagged bytes, clear requests and discarded lines give none.
// line_limit sits at byte address 0 of the APB port and must only be written
// while the parser is idle.
module ascii_vision_packet_line_parser #(
  parameter int LINE_BUFFER = avpl_pkg::LineBufferDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  avpl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output avpl_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                s1_valid_r;
  avpl_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  avpl_pkg::out_item_t out_data_r;
  logic [6:0]          limit_r;
  logic                go;
  logic                res_valid;
  avpl_pkg::out_item_t res;

  assign go        = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2:1] == avpl_pkg::AddrLineLimit) ? {25'd0, limit_r} : 32'd0;

  avpl_line_core #(
    .LINE_BUFFER(LINE_BUFFER)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .item      (s1_item_r),
    .line_limit(limit_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= avpl_pkg::LimitReset;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (go && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite && paddr[2:1] == avpl_pkg::AddrLineLimit) begin
        limit_r <= pwdata[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) s1_item_r <= in_data;
    if (go && res_valid) out_data_r <= res;
  end

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked item");

  a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.confidence <= avpl_pkg::ConfMax))
    else $error("confidence above clamp");

  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != avpl_pkg::KIND_TAG) |-> (out_data.tag_id == 16'sd0))
    else $error("tag field set on non-tag line");

endmodule
